/* design/fke_pkg.sv */
package fke_pkg;

    // Frame layout and protocol codes
    localparam logic [15:0] ETH_HDR_LEN    = 16'd14;
    localparam logic [15:0] MIN_CAPTURE    = 16'd34;
    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  PROTO_TCP      = 8'd6;
    localparam logic [7:0]  PROTO_UDP      = 8'd17;
    localparam logic [3:0]  IHL_MASK       = 4'hF;
    localparam logic [7:0]  TCP_SYN_MASK   = 8'h02;
    localparam logic [7:0]  TCP_FIN_MASK   = 8'h01;
    localparam logic [7:0]  TCP_RST_MASK   = 8'h04;

    // Fixed byte positions inside the frame
    localparam logic [15:0] POS_ETYPE_HI   = 16'd12;
    localparam logic [15:0] POS_ETYPE_LO   = 16'd13;
    localparam logic [15:0] POS_IHL        = 16'd14;
    localparam logic [15:0] POS_PROTO      = 16'd23;
    localparam logic [15:0] POS_SRC_ADDR   = 16'd26;
    localparam logic [15:0] POS_DST_ADDR   = 16'd30;
    localparam logic [15:0] POS_ADDR_END   = 16'd34;
    localparam logic [15:0] COUNT_MAX      = 16'hFFFF;

    // Offsets from the start of the L4 header
    localparam logic [15:0] L4_MIN_LEN     = 16'd4;
    localparam logic [15:0] L4_FLAG_POS    = 16'd13;
    localparam logic [15:0] L4_FLAG_LEN    = 16'd14;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        end_of_packet;
        logic [15:0] wire_length;
    } in_item_t;

    typedef struct packed {
        logic        accepted;
        logic [31:0] addr_low;
        logic [31:0] addr_high;
        logic [15:0] port_low;
        logic [15:0] port_high;
        logic [7:0]  protocol;
        logic        syn_seen;
        logic        fin_or_rst;
        logic [15:0] frame_length;
    } out_item_t;

    // Header fields of the current frame, including the byte in flight
    typedef struct packed {
        logic [15:0] cap_len;
        logic [15:0] ether_type;
        logic [5:0]  header_bytes;
        logic [7:0]  protocol_byte;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [7:0]  flag_byte;
    } frame_fields_t;

endpackage

/* design/fke_field_capture.sv */
module fke_field_capture (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   advance,
    input  fke_pkg::in_item_t      item,
    output fke_pkg::frame_fields_t fields
);

    logic [15:0] count_reg, count_next;
    logic [15:0] ether_type_reg;
    logic [5:0]  header_bytes_reg;
    logic [7:0]  protocol_byte_reg;
    logic [31:0] src_addr_reg;
    logic [31:0] dst_addr_reg;
    logic [15:0] src_port_reg;
    logic [15:0] dst_port_reg;
    logic [7:0]  flag_byte_reg;

    fke_pkg::frame_fields_t upd;
    logic [7:0]  b;
    logic [15:0] pos;
    logic [15:0] l4_base;
    logic [15:0] src_off;
    logic [15:0] dst_off;

    assign b   = item.data_byte;
    assign pos = count_reg;

    // Merge the current byte into the header fields
    always_comb
    begin
        upd.ether_type    = ether_type_reg;
        upd.header_bytes  = header_bytes_reg;
        upd.protocol_byte = protocol_byte_reg;
        upd.src_addr      = src_addr_reg;
        upd.dst_addr      = dst_addr_reg;
        upd.src_port      = src_port_reg;
        upd.dst_port      = dst_port_reg;
        upd.flag_byte     = flag_byte_reg;
        src_off           = pos - fke_pkg::POS_SRC_ADDR;
        dst_off           = pos - fke_pkg::POS_DST_ADDR;

        if (pos == fke_pkg::POS_ETYPE_HI)
        begin
            upd.ether_type[15:8] = b;
        end
        if (pos == fke_pkg::POS_ETYPE_LO)
        begin
            upd.ether_type[7:0] = b;
        end
        if (pos == fke_pkg::POS_IHL)
        begin
            upd.header_bytes = {b[3:0] & fke_pkg::IHL_MASK, 2'b00};
        end
        if (pos == fke_pkg::POS_PROTO)
        begin
            upd.protocol_byte = b;
        end
        if (pos >= fke_pkg::POS_SRC_ADDR && pos < fke_pkg::POS_DST_ADDR)
        begin
            upd.src_addr = upd.src_addr | ({24'd0, b} << {src_off[1:0], 3'b000});
        end
        if (pos >= fke_pkg::POS_DST_ADDR && pos < fke_pkg::POS_ADDR_END)
        begin
            upd.dst_addr = upd.dst_addr | ({24'd0, b} << {dst_off[1:0], 3'b000});
        end

        // L4 positions follow the header length as it stands after this byte
        l4_base = fke_pkg::ETH_HDR_LEN + {10'd0, upd.header_bytes};
        if (pos == l4_base)
        begin
            upd.src_port[15:8] = b;
        end
        if (pos == l4_base + 16'd1)
        begin
            upd.src_port[7:0] = b;
        end
        if (pos == l4_base + 16'd2)
        begin
            upd.dst_port[15:8] = b;
        end
        if (pos == l4_base + 16'd3)
        begin
            upd.dst_port[7:0] = b;
        end
        if (pos == l4_base + fke_pkg::L4_FLAG_POS)
        begin
            upd.flag_byte = b;
        end

        // Saturate the byte count
        count_next  = (count_reg == fke_pkg::COUNT_MAX) ? count_reg : count_reg + 16'd1;
        upd.cap_len = count_next;
    end

    assign fields = upd;

    // Hold fields between bytes, clear after the last byte of a frame
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg         <= '0;
            ether_type_reg    <= '0;
            header_bytes_reg  <= '0;
            protocol_byte_reg <= '0;
            src_addr_reg      <= '0;
            dst_addr_reg      <= '0;
            src_port_reg      <= '0;
            dst_port_reg      <= '0;
            flag_byte_reg     <= '0;
        end
        else if (advance)
        begin
            if (item.end_of_packet)
            begin
                count_reg         <= '0;
                ether_type_reg    <= '0;
                header_bytes_reg  <= '0;
                protocol_byte_reg <= '0;
                src_addr_reg      <= '0;
                dst_addr_reg      <= '0;
                src_port_reg      <= '0;
                dst_port_reg      <= '0;
                flag_byte_reg     <= '0;
            end
            else
            begin
                count_reg         <= count_next;
                ether_type_reg    <= upd.ether_type;
                header_bytes_reg  <= upd.header_bytes;
                protocol_byte_reg <= upd.protocol_byte;
                src_addr_reg      <= upd.src_addr;
                dst_addr_reg      <= upd.dst_addr;
                src_port_reg      <= upd.src_port;
                dst_port_reg      <= upd.dst_port;
                flag_byte_reg     <= upd.flag_byte;
            end
        end
    end

endmodule

/* design/fke_key_order.sv */
module fke_key_order (
    input  fke_pkg::frame_fields_t fields,
    input  logic [15:0]            wire_length,
    output fke_pkg::out_item_t     result
);

    logic [15:0] l4_base;
    logic        proto_ok;
    logic        ok;
    logic        keep;
    logic        flags_ok;

    // Qualify the frame and order the endpoints
    always_comb
    begin
        l4_base  = fke_pkg::ETH_HDR_LEN + {10'd0, fields.header_bytes};
        proto_ok = (fields.protocol_byte == fke_pkg::PROTO_TCP)
                || (fields.protocol_byte == fke_pkg::PROTO_UDP);
        ok       = (fields.cap_len >= fke_pkg::MIN_CAPTURE)
                && (fields.ether_type == fke_pkg::ETHERTYPE_IPV4)
                && (fields.cap_len >= l4_base + fke_pkg::L4_MIN_LEN)
                && proto_ok;
        keep     = (fields.src_addr < fields.dst_addr)
                || ((fields.src_addr == fields.dst_addr)
                    && (fields.src_port <= fields.dst_port));
        flags_ok = (fields.protocol_byte == fke_pkg::PROTO_TCP)
                && (fields.cap_len >= l4_base + fke_pkg::L4_FLAG_LEN);

        result              = '0;
        result.frame_length = wire_length;
        if (ok)
        begin
            result.accepted  = 1'b1;
            result.addr_low  = keep ? fields.src_addr : fields.dst_addr;
            result.addr_high = keep ? fields.dst_addr : fields.src_addr;
            result.port_low  = keep ? fields.src_port : fields.dst_port;
            result.port_high = keep ? fields.dst_port : fields.src_port;
            result.protocol  = fields.protocol_byte;
            if (flags_ok)
            begin
                result.syn_seen   = |(fields.flag_byte & fke_pkg::TCP_SYN_MASK);
                result.fin_or_rst =
                    |(fields.flag_byte & (fke_pkg::TCP_FIN_MASK | fke_pkg::TCP_RST_MASK));
            end
        end
    end

endmodule

/* design/ipv4_flow_key_extractor.sv */
// Channel | Handshake            | Payload                 | Transfers
// in      | in_valid / in_ready  | in_data (in_item_t)     | one frame byte
// out     | out_valid / out_ready| out_data (out_item_t)   | one flow key per frame
//
// One byte per cycle while no result stalls; a byte passes the input register, then field
// capture and key ordering, and a frame's result lands in the output register.
// out_valid is set when the output register takes a last byte's result while it is free.
// rst_n clears the frame state and both valid flags.
// A stalled result blocks only a last byte; other bytes keep flowing.
module ipv4_flow_key_extractor (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  fke_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output fke_pkg::out_item_t out_data
);

    fke_pkg::in_item_t      in_reg;
    logic                   in_valid_reg, in_valid_next;
    fke_pkg::out_item_t     out_reg;
    logic                   out_valid_reg, out_valid_next;
    fke_pkg::frame_fields_t fields;
    fke_pkg::out_item_t     result;
    logic                   advance;
    logic                   emit;

    // Advance the held byte unless it ends a frame and the result slot is full
    assign advance  = in_valid_reg
                   && !(in_reg.end_of_packet && out_valid_reg && !out_ready);
    assign emit     = advance && in_reg.end_of_packet;
    assign in_ready = !in_valid_reg || advance;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_valid && in_ready)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    fke_field_capture u_capture (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (in_reg),
        .fields  (fields)
    );

    fke_key_order u_order (
        .fields      (fields),
        .wire_length (in_reg.wire_length),
        .result      (result)
    );

    // Hold valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture payloads on transfer
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_reg <= in_data;
        end
        if (emit)
        begin
            out_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule
